>>> hdl/spf_pkg.sv
// Shared constants for the stationary pose freeze unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package spf_pkg;
  // field widths
  localparam int POS_W   = 32;
  localparam int QUAT_W  = 16;
  localparam int TIME_W  = 40;
  localparam int MDT_W   = 16;
  localparam int STT_W   = 26;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // squares of position steps go through a 32-bit serial squarer
  localparam int SQ_W      = 32;
  localparam int SQ_CYCLES = 32;

  localparam int QUAT_FRAC_BITS_DEF = 14;

  // register reset values
  localparam logic [MDT_W-1:0] MOVE_DIST_RST = 16'd1311;
  localparam logic [STT_W-1:0] STILL_RST     = 26'd500000;

  // register index (paddr bit 2)
  localparam logic REG_MOVE_DIST = 1'b0;
  localparam logic REG_STILL     = 1'b1;
endpackage
`default_nettype wire

>>> hdl/stationary_pose_freeze_unit.sv
// Stationary pose freeze unit: top level.
// Depends on spf_pkg, spf_sqr, spf_norm.
//
// Input channel (in_valid/in_stall) takes one odometry pose per transfer.
// Flagged poses and poses with an all-zero quaternion are taken and
// dropped at once with no result. Other poses give one result on the
// output channel (out_valid/out_stall).
// Each pose runs eight squares (three position steps, threshold, four
// quaternion parts) in turn through one bit-serial squarer up to the
// decision. A frozen result is then ready.
// A live result normalizes four components in turn, each on a serial
// divider and then a square root.
// One pose is worked on at a time; in_stall is high while busy.
// The result sits in an output register; the next pose is taken while it
// waits. If out_stall holds, a finished pose waits until the register
// frees up. Reset clears the pose history, the freeze, and sets the
// registers to 0.02 m and 0.5 s; no clearing pass is needed.
// APB registers: 0x0 move distance threshold, 0x4 still time threshold.
`default_nettype none
module stationary_pose_freeze_unit
  import spf_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [POS_W-1:0]  pos_z,
  input  wire logic signed [QUAT_W-1:0] quat_x,
  input  wire logic signed [QUAT_W-1:0] quat_y,
  input  wire logic signed [QUAT_W-1:0] quat_z,
  input  wire logic signed [QUAT_W-1:0] quat_w,
  input  wire logic [TIME_W-1:0]        sample_time,
  input  wire logic [TIME_W-1:0]        arrival_time,
  input  wire logic                     not_finite,
  // output channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [POS_W-1:0]       out_pos_x,
  output logic signed [POS_W-1:0]       out_pos_y,
  output logic signed [POS_W-1:0]       out_pos_z,
  output logic signed [QUAT_W-1:0]      out_quat_x,
  output logic signed [QUAT_W-1:0]      out_quat_y,
  output logic signed [QUAT_W-1:0]      out_quat_z,
  output logic signed [QUAT_W-1:0]      out_quat_w,
  output logic [TIME_W-1:0]             out_time,
  output logic                          is_frozen
);
  localparam int ROOT_W = QUAT_FRAC_BITS + 2;
  localparam int S_W    = 2*QUAT_W + 1;
  localparam int QSQ_W  = 2*QUAT_W - 1;
  localparam int P2_W   = 2*SQ_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;
  localparam logic [2:0] S_SQ      = 3'd2;
  localparam logic [2:0] S_DECIDE  = 3'd3;
  localparam logic [2:0] S_NORM_GO = 3'd4;
  localparam logic [2:0] S_NORM    = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  localparam logic [2:0] JOB_THR   = 3'd3;
  localparam logic [2:0] JOB_LAST  = 3'd7;

  logic [2:0]              state;
  logic [2:0]              job;
  logic [1:0]              comp;

  logic [MDT_W-1:0]        move_dist;
  logic [STT_W-1:0]        still_time;

  logic signed [POS_W-1:0]  p     [3];
  logic signed [QUAT_W-1:0] q     [4];
  logic [TIME_W-1:0]        ts;
  logic [TIME_W-1:0]        now;
  logic signed [POS_W-1:0]  prev  [3];
  logic signed [POS_W-1:0]  held  [3];
  logic signed [QUAT_W-1:0] hq    [4];
  logic [TIME_W-1:0]        move_time;
  logic                     freeze;

  logic [P2_W-1:0]          d2;
  logic [SQ_W-1:0]          th2;
  logic [QSQ_W-1:0]         qsq   [4];
  logic [S_W-1:0]           ssum;
  logic signed [QUAT_W-1:0] kres  [4];

  logic                     in_take;
  logic                     drop;
  logic                     out_free;

  logic                     sqr_start;
  logic                     sqr_done;
  logic [SQ_W-1:0]          sqr_mag;
  logic [P2_W-1:0]          sqr_prod;
  logic                     norm_start;
  logic                     norm_done;
  logic [ROOT_W-1:0]        norm_k;

  logic signed [POS_W:0]    dlt;
  logic [POS_W:0]           dmag;
  logic [QUAT_W-1:0]        qmag;
  logic [P2_W:0]            d2_sum;
  logic                     moving;
  logic [TIME_W-1:0]        mt_new;
  logic                     frz_a;
  logic [TIME_W:0]          elapsed;
  logic                     frz_b;
  logic [QUAT_W-1:0]        kext;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      move_dist  <= MOVE_DIST_RST;
      still_time <= STILL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MOVE_DIST: move_dist  <= pwdata[MDT_W-1:0];
        REG_STILL:     still_time <= pwdata[STT_W-1:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_STILL) ? DATA_W'(still_time) : DATA_W'(move_dist);

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign drop     = not_finite ||
                    (quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0);
  assign out_free = !out_valid || !out_stall;

  // squarer operand select
  always_comb begin
    dlt  = {p[job[1:0]][POS_W-1], p[job[1:0]]} - {prev[job[1:0]][POS_W-1], prev[job[1:0]]};
    dmag = dlt[POS_W] ? POS_W'(-dlt) : dlt;
    qmag = q[job[1:0]][QUAT_W-1] ? QUAT_W'(-q[job[1:0]]) : q[job[1:0]];
    if (job < JOB_THR)       sqr_mag = dmag[SQ_W-1:0];
    else if (job == JOB_THR) sqr_mag = SQ_W'(move_dist);
    else                     sqr_mag = SQ_W'(qmag);
  end
  assign sqr_start = (state == S_LOAD);
  assign d2_sum    = {1'b0, d2} + {1'b0, sqr_prod};

  // motion and freeze decision
  always_comb begin
    moving  = (d2 > P2_W'(th2));
    mt_new  = moving ? ts : move_time;
    frz_a   = moving ? 1'b0 : freeze;
    elapsed = {1'b0, now} - {1'b0, mt_new};
    frz_b   = frz_a || (!elapsed[TIME_W] && (elapsed[TIME_W-1:0] > TIME_W'(still_time)));
  end

  assign norm_start = (state == S_NORM_GO);
  assign kext       = QUAT_W'(norm_k);

  spf_sqr u_sqr (
    .clk   (clk),
    .rst   (rst),
    .start (sqr_start),
    .mag   (sqr_mag),
    .done  (sqr_done),
    .prod  (sqr_prod)
  );

  spf_norm #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sq    (qsq[comp]),
    .ssum  (ssum),
    .done  (norm_done),
    .k     (norm_k)
  );

  // sequencer and pose history
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= '0;
      comp      <= '0;
      move_time <= '0;
      freeze    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
        held[i] <= '0;
      end
      for (int i = 0; i < 3; i++) hq[i] <= '0;
      hq[3] <= QUAT_W'(1 << QUAT_FRAC_BITS);
    end else begin
      // a new result loaded in S_OUT takes the place of the one leaving
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_take && !drop) begin
            state <= S_LOAD;
            job   <= '0;
          end
        end
        S_LOAD: state <= S_SQ;
        S_SQ: begin
          if (sqr_done) begin
            if (job == JOB_LAST) state <= S_DECIDE;
            else begin
              job   <= job + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_DECIDE: begin
          move_time <= mt_new;
          freeze    <= frz_b;
          if (!frz_a) begin
            for (int i = 0; i < 3; i++) held[i] <= p[i];
            for (int i = 0; i < 4; i++) hq[i] <= q[i];
          end
          for (int i = 0; i < 3; i++) prev[i] <= p[i];
          comp  <= '0;
          state <= frz_b ? S_OUT : S_NORM_GO;
        end
        S_NORM_GO: state <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            if (comp == 2'd3) state <= S_OUT;
            else begin
              comp  <= comp + 1'b1;
              state <= S_NORM_GO;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture and sum accumulation
  always_ff @(posedge clk) begin
    if (in_take) begin
      p[0] <= pos_x;
      p[1] <= pos_y;
      p[2] <= pos_z;
      q[0] <= quat_x;
      q[1] <= quat_y;
      q[2] <= quat_z;
      q[3] <= quat_w;
      ts   <= sample_time;
      now  <= arrival_time;
      d2   <= '0;
      ssum <= '0;
    end
    if (state == S_SQ && sqr_done) begin
      if (job < JOB_THR)       d2  <= d2_sum[P2_W] ? '1 : d2_sum[P2_W-1:0];
      else if (job == JOB_THR) th2 <= sqr_prod[SQ_W-1:0];
      else begin
        qsq[job[1:0]] <= sqr_prod[QSQ_W-1:0];
        ssum          <= ssum + sqr_prod[S_W-1:0];
      end
    end
    if (state == S_NORM && norm_done)
      kres[comp] <= q[comp][QUAT_W-1] ? QUAT_W'(-kext) : kext;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_time  <= ts;
      is_frozen <= freeze;
      if (freeze) begin
        out_pos_x  <= held[0];
        out_pos_y  <= held[1];
        out_pos_z  <= held[2];
        out_quat_x <= hq[0];
        out_quat_y <= hq[1];
        out_quat_z <= hq[2];
        out_quat_w <= hq[3];
      end else begin
        out_pos_x  <= p[0];
        out_pos_y  <= p[1];
        out_pos_z  <= p[2];
        out_quat_x <= kres[0];
        out_quat_y <= kres[1];
        out_quat_z <= kres[2];
        out_quat_w <= kres[3];
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/spf_sqr.sv
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
// Depends on spf_pkg.
`default_nettype none
module spf_sqr
  import spf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   mag,
  output logic                   done,
  output logic [2*SQ_W-1:0]      prod
);
  localparam int CNT_W = $clog2(SQ_CYCLES);

  logic [2*SQ_W-1:0] mcand;
  logic [SQ_W-1:0]   mplier;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: add shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= {{SQ_W{1'b0}}, mag};
      mplier <= mag;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= {mcand[2*SQ_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[SQ_W-1:1]};
    end
  end
endmodule
`default_nettype wire

>>> hdl/spf_norm.sv
// Serial normalizer for one quaternion component: restoring divide of
// q^2 * 4^(Q+1) by the sum of squares, then a 2-bit-per-step square root.
// Depends on spf_pkg.
`default_nettype none
module spf_norm
  import spf_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [2*QUAT_W-2:0]       sq,
  input  wire logic [2*QUAT_W:0]         ssum,
  output logic                           done,
  output logic [QUAT_FRAC_BITS+1:0]      k
);
  localparam int DIV_BITS = 2*QUAT_FRAC_BITS + 3;
  localparam int STEPS    = QUAT_FRAC_BITS + 2;
  localparam int ROOT_W   = QUAT_FRAC_BITS + 2;
  localparam int RW       = QUAT_FRAC_BITS + 5;
  localparam int SIN_W    = 2*STEPS;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam int S_W      = 2*QUAT_W + 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]          phase;
  logic [CNT_W-1:0]    cnt;
  logic [S_W-1:0]      rem;
  logic [DIV_BITS-1:0] dvl;
  logic [DIV_BITS-1:0] qt;
  logic [SIN_W-1:0]    n;
  logic [RW-1:0]       sr;
  logic [ROOT_W-1:0]   rt;

  logic [S_W:0]        t;
  logic                dge;
  logic [S_W-1:0]      rem_next;
  logic [DIV_BITS-1:0] qt_next;
  logic [RW-1:0]       r2;
  logic [RW-1:0]       trial;
  logic                sge;
  logic [ROOT_W-1:0]   rt_next;
  logic [ROOT_W:0]     rnd;

  // one divide step
  always_comb begin
    t        = {rem, dvl[DIV_BITS-1]};
    dge      = (t >= {1'b0, ssum});
    rem_next = dge ? S_W'(t - {1'b0, ssum}) : t[S_W-1:0];
    qt_next  = {qt[DIV_BITS-2:0], dge};
  end

  // one square root step
  always_comb begin
    r2      = {sr[RW-3:0], n[SIN_W-1 -: 2]};
    trial   = RW'({rt, 2'b01});
    sge     = (r2 >= trial);
    rt_next = {rt[ROOT_W-2:0], sge};
    rnd     = {1'b0, rt_next} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_DIV;
            cnt   <= '0;
          end
        end
        PH_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_BITS - 1)) begin
            phase <= PH_SQRT;
            cnt   <= '0;
          end
        end
        PH_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // datapath; dividend high part is sq/2, low part sq[0] then zeros
  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          rem <= S_W'(sq >> 1);
          dvl <= {sq[0], {(DIV_BITS-1){1'b0}}};
          qt  <= '0;
        end
      end
      PH_DIV: begin
        rem <= rem_next;
        dvl <= {dvl[DIV_BITS-2:0], 1'b0};
        qt  <= qt_next;
        if (cnt == CNT_W'(DIV_BITS - 1)) begin
          n  <= {1'b0, qt_next};
          sr <= '0;
          rt <= '0;
        end
      end
      PH_SQRT: begin
        sr <= sge ? RW'(r2 - trial) : r2;
        rt <= rt_next;
        n  <= {n[SIN_W-3:0], 2'b00};
        // nearest k is (root + 1) / 2
        if (cnt == CNT_W'(STEPS - 1)) k <= rnd[ROOT_W:1];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/spf_chk.sv
// Port-level checks for the stationary pose freeze unit, bound to the top.
// Depends on spf_pkg and stationary_pose_freeze_unit.
`default_nettype none
module spf_chk
  import spf_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     not_finite,
  input wire logic signed [QUAT_W-1:0] quat_x,
  input wire logic signed [QUAT_W-1:0] quat_y,
  input wire logic signed [QUAT_W-1:0] quat_z,
  input wire logic signed [QUAT_W-1:0] quat_w,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [POS_W-1:0]  out_pos_x,
  input wire logic signed [QUAT_W-1:0] out_quat_w,
  input wire logic [TIME_W-1:0]        out_time,
  input wire logic                     is_frozen
);
  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_time)
      && $stable(is_frozen))
    else $error("stalled result changed");

  // a kept pose blocks the input while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !not_finite &&
    (quat_x != 0 || quat_y != 0 || quat_z != 0 || quat_w != 0) |=> in_stall)
    else $error("input taken while a pose is in work");

  // the live quaternion w part stays within unit scale
  a_live_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frozen |-> out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384)
    else $error("live quaternion out of range");
endmodule

bind stationary_pose_freeze_unit spf_chk u_spf_chk (.*);
`default_nettype wire
